// File: hdl/bcrf_pkg.sv
// bcrf_pkg: shared types, constants and the microcode table of the bisection root finder
// no dependencies; used by bcrf_useq, bcrf_datapath, the core and the test bench modules
package bcrf_pkg;

    localparam int ACC_W     = 64;
    localparam int COEF_W    = 16;
    localparam int TOL_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int UPC_W     = 5;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_CUBE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_SQUARE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LINEAR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_CONST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 3'd4;

    localparam logic signed [COEF_W-1:0] RST_COEF_CUBE   = 16'sd2;
    localparam logic signed [COEF_W-1:0] RST_COEF_SQUARE = -16'sd9;
    localparam logic signed [COEF_W-1:0] RST_COEF_LINEAR = -16'sd60;
    localparam logic signed [COEF_W-1:0] RST_COEF_CONST  = 16'sd1;
    localparam logic [TOL_W-1:0]         RST_TOLERANCE   = 24'd66;

    // microcode addresses
    localparam logic [UPC_W-1:0] UPC_WAIT   = 5'd0;
    localparam logic [UPC_W-1:0] UPC_EVAL_A = 5'd1;
    localparam logic [UPC_W-1:0] UPC_EVAL_B = 5'd2;
    localparam logic [UPC_W-1:0] UPC_CHECK  = 5'd3;
    localparam logic [UPC_W-1:0] UPC_LOOP   = 5'd4;
    localparam logic [UPC_W-1:0] UPC_UPDATE = 5'd5;
    localparam logic [UPC_W-1:0] UPC_OUT    = 5'd6;
    localparam logic [UPC_W-1:0] UPC_EVAL   = 5'd8;

    typedef enum logic [3:0] {
        UOP_WAIT,
        UOP_EVAL_A,
        UOP_EVAL_B,
        UOP_CHECK,
        UOP_LOOP,
        UOP_UPDATE,
        UOP_OUT,
        UOP_MUL_HI,
        UOP_MUL_LO,
        UOP_ADD,
        UOP_ADD_RET
    } uop_t;

    typedef enum logic [1:0] {
        COEF_SQUARE,
        COEF_LINEAR,
        COEF_CONST
    } coef_sel_t;

    typedef struct packed {
        uop_t             uop;
        coef_sel_t        coef;
        logic [UPC_W-1:0] target;
    } ctl_t;

    typedef struct packed {
        logic same_sign;
        logic within_tol;
        logic out_free;
    } stat_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] cube;
        logic signed [COEF_W-1:0] square;
        logic signed [COEF_W-1:0] linear;
        logic signed [COEF_W-1:0] offset;
        logic [TOL_W-1:0]         tol;
    } cfg_t;

    function automatic ctl_t ucode_rom(input logic [UPC_W-1:0] pc);
        ctl_t w;
        w = '{uop: UOP_WAIT, coef: COEF_SQUARE, target: UPC_WAIT};
        case (pc)
            5'd0:    w = '{uop: UOP_WAIT,    coef: COEF_SQUARE, target: UPC_WAIT};
            5'd1:    w = '{uop: UOP_EVAL_A,  coef: COEF_SQUARE, target: UPC_EVAL};
            5'd2:    w = '{uop: UOP_EVAL_B,  coef: COEF_SQUARE, target: UPC_EVAL};
            5'd3:    w = '{uop: UOP_CHECK,   coef: COEF_SQUARE, target: UPC_OUT};
            5'd4:    w = '{uop: UOP_LOOP,    coef: COEF_SQUARE, target: UPC_OUT};
            5'd5:    w = '{uop: UOP_UPDATE,  coef: COEF_SQUARE, target: UPC_LOOP};
            5'd6:    w = '{uop: UOP_OUT,     coef: COEF_SQUARE, target: UPC_WAIT};
            5'd8:    w = '{uop: UOP_MUL_HI,  coef: COEF_SQUARE, target: UPC_WAIT};
            5'd9:    w = '{uop: UOP_MUL_LO,  coef: COEF_SQUARE, target: UPC_WAIT};
            5'd10:   w = '{uop: UOP_ADD,     coef: COEF_SQUARE, target: UPC_WAIT};
            5'd11:   w = '{uop: UOP_MUL_HI,  coef: COEF_LINEAR, target: UPC_WAIT};
            5'd12:   w = '{uop: UOP_MUL_LO,  coef: COEF_LINEAR, target: UPC_WAIT};
            5'd13:   w = '{uop: UOP_ADD,     coef: COEF_LINEAR, target: UPC_WAIT};
            5'd14:   w = '{uop: UOP_MUL_HI,  coef: COEF_CONST,  target: UPC_WAIT};
            5'd15:   w = '{uop: UOP_MUL_LO,  coef: COEF_CONST,  target: UPC_WAIT};
            5'd16:   w = '{uop: UOP_ADD_RET, coef: COEF_CONST,  target: UPC_WAIT};
            default: w = '{uop: UOP_WAIT,    coef: COEF_SQUARE, target: UPC_WAIT};
        endcase
        return w;
    endfunction

endpackage

// File: hdl/bcrf_useq.sv
// bcrf_useq: microprogram counter, return register and control word fetch
// depends on bcrf_pkg (microcode table, control and status types)
module bcrf_useq
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  bcrf_pkg::stat_t stat,
    output bcrf_pkg::ctl_t  ctl
);

    logic [bcrf_pkg::UPC_W-1:0] pc_reg;
    logic [bcrf_pkg::UPC_W-1:0] pc_next;
    logic [bcrf_pkg::UPC_W-1:0] ret_reg;
    logic [bcrf_pkg::UPC_W-1:0] ret_next;
    logic [bcrf_pkg::UPC_W-1:0] pc_inc;

    assign ctl    = bcrf_pkg::ucode_rom(pc_reg);
    assign pc_inc = pc_reg + bcrf_pkg::UPC_W'(1);

    always_comb
    begin
        pc_next  = pc_inc;
        ret_next = ret_reg;
        case (ctl.uop)
            bcrf_pkg::UOP_WAIT:
            begin
                pc_next = in_valid ? pc_inc : pc_reg;
            end
            bcrf_pkg::UOP_EVAL_A,
            bcrf_pkg::UOP_EVAL_B:
            begin
                ret_next = pc_inc;
                pc_next  = ctl.target;
            end
            bcrf_pkg::UOP_CHECK:
            begin
                pc_next = stat.same_sign ? ctl.target : pc_inc;
            end
            bcrf_pkg::UOP_LOOP:
            begin
                if (stat.within_tol)
                begin
                    pc_next = ctl.target;
                end
                else
                begin
                    ret_next = pc_inc;
                    pc_next  = bcrf_pkg::UPC_EVAL;
                end
            end
            bcrf_pkg::UOP_UPDATE:
            begin
                pc_next = ctl.target;
            end
            bcrf_pkg::UOP_OUT:
            begin
                pc_next = stat.out_free ? ctl.target : pc_reg;
            end
            bcrf_pkg::UOP_ADD_RET:
            begin
                pc_next = ret_reg;
            end
            default:
            begin
                pc_next = pc_inc;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= bcrf_pkg::UPC_WAIT;
            ret_reg <= bcrf_pkg::UPC_WAIT;
        end
        else
        begin
            pc_reg  <= pc_next;
            ret_reg <= ret_next;
        end
    end

endmodule

// File: hdl/bcrf_datapath.sv
// bcrf_datapath: interval registers, shared horner multiplier, accumulator and result register
// depends on bcrf_pkg (control word, status and configuration types)
module bcrf_datapath
#(
    parameter int FRAC_BITS = 16,
    parameter int X_BITS    = 24
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  bcrf_pkg::ctl_t           ctl,
    input  bcrf_pkg::cfg_t           cfg,
    input  logic                     in_valid,
    input  logic signed [X_BITS-1:0] interval_start,
    input  logic signed [X_BITS-1:0] interval_end,
    input  logic                     out_stall,
    output bcrf_pkg::stat_t          stat,
    output logic                     out_valid,
    output logic signed [X_BITS-1:0] root,
    output logic                     no_sign_change
);

    localparam int ACC_W    = bcrf_pkg::ACC_W;
    localparam int AW       = ACC_W - X_BITS;
    localparam int CW       = (X_BITS + 1 > bcrf_pkg::TOL_W) ? X_BITS + 1 : bcrf_pkg::TOL_W;
    localparam int COEF_W_L = bcrf_pkg::COEF_W;
    localparam logic signed [ACC_W-1:0] HCLAMP_POS =
        {{(X_BITS + 1){1'b0}}, 1'b1, {(62 - X_BITS){1'b0}}};
    localparam logic signed [ACC_W-1:0] HCLAMP_NEG = -HCLAMP_POS;

    logic signed [X_BITS-1:0] a_reg;
    logic signed [X_BITS-1:0] a_next;
    logic signed [X_BITS-1:0] b_reg;
    logic signed [X_BITS-1:0] b_next;
    logic signed [X_BITS-1:0] x_reg;
    logic signed [X_BITS-1:0] x_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]  prod_next;
    logic signed [ACC_W-1:0]  sum_reg;
    logic signed [ACC_W-1:0]  sum_next;
    logic                     sa_pos_reg;
    logic                     sa_pos_next;
    logic                     sa_neg_reg;
    logic                     sa_neg_next;
    logic                     err_reg;
    logic                     err_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [X_BITS-1:0] root_reg;
    logic signed [X_BITS-1:0] root_next;
    logic                     nsc_reg;
    logic                     nsc_next;

    logic signed [ACC_W-1:0]  hi_full;
    logic signed [ACC_W-1:0]  hi_clamped;
    logic signed [AW-1:0]     mul_a;
    logic signed [ACC_W-1:0]  prod_full;
    logic signed [COEF_W_L-1:0] coef_cur;
    logic signed [ACC_W-1:0]  coef_shifted;
    logic signed [ACC_W-1:0]  cube_shifted;
    logic signed [ACC_W-1:0]  horner_sum;
    logic                     acc_pos;
    logic                     acc_neg;
    logic signed [X_BITS:0]   ab_sum;
    logic signed [X_BITS:0]   ab_diff;
    logic [X_BITS:0]          ab_mag;
    logic [bcrf_pkg::TOL_W-1:0] tol_eff;
    logic                     out_free;

    // horner arithmetic
    assign hi_full = acc_reg >>> FRAC_BITS;

    always_comb
    begin
        if (hi_full > HCLAMP_POS)
        begin
            hi_clamped = HCLAMP_POS;
        end
        else if (hi_full < HCLAMP_NEG)
        begin
            hi_clamped = HCLAMP_NEG;
        end
        else
        begin
            hi_clamped = hi_full;
        end
    end

    assign mul_a = (ctl.uop == bcrf_pkg::UOP_MUL_LO)
                 ? signed'({{(AW - FRAC_BITS){1'b0}}, acc_reg[FRAC_BITS-1:0]})
                 : hi_clamped[AW-1:0];
    assign prod_full = mul_a * x_reg;

    always_comb
    begin
        case (ctl.coef)
            bcrf_pkg::COEF_SQUARE: coef_cur = cfg.square;
            bcrf_pkg::COEF_LINEAR: coef_cur = cfg.linear;
            bcrf_pkg::COEF_CONST:  coef_cur = cfg.offset;
            default:               coef_cur = cfg.offset;
        endcase
    end

    assign coef_shifted = {{(ACC_W - COEF_W_L){coef_cur[COEF_W_L-1]}}, coef_cur} <<< FRAC_BITS;
    assign cube_shifted = {{(ACC_W - COEF_W_L){cfg.cube[COEF_W_L-1]}}, cfg.cube} <<< FRAC_BITS;
    assign horner_sum   = sum_reg + (prod_reg >>> FRAC_BITS) + coef_shifted;

    assign acc_neg = acc_reg[ACC_W-1];
    assign acc_pos = !acc_reg[ACC_W-1] && (|acc_reg);

    // interval arithmetic
    assign ab_sum  = {a_reg[X_BITS-1], a_reg} + {b_reg[X_BITS-1], b_reg};
    assign ab_diff = {a_reg[X_BITS-1], a_reg} - {b_reg[X_BITS-1], b_reg};
    assign ab_mag  = ab_diff[X_BITS] ? (X_BITS + 1)'(-ab_diff) : ab_diff;
    assign tol_eff = (cfg.tol == '0) ? bcrf_pkg::TOL_W'(1) : cfg.tol;

    assign out_free        = !out_valid_reg || !out_stall;
    assign stat.out_free   = out_free;
    assign stat.same_sign  = (sa_pos_reg && acc_pos) || (sa_neg_reg && acc_neg);
    assign stat.within_tol = CW'(ab_mag) <= CW'(tol_eff);

    always_comb
    begin
        a_next         = a_reg;
        b_next         = b_reg;
        x_next         = x_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        sa_pos_next    = sa_pos_reg;
        sa_neg_next    = sa_neg_reg;
        err_next       = err_reg;
        root_next      = root_reg;
        nsc_next       = nsc_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (ctl.uop)
            bcrf_pkg::UOP_WAIT:
            begin
                if (in_valid)
                begin
                    a_next = interval_start;
                    b_next = interval_end;
                end
            end
            bcrf_pkg::UOP_EVAL_A:
            begin
                x_next   = a_reg;
                acc_next = cube_shifted;
            end
            bcrf_pkg::UOP_EVAL_B:
            begin
                sa_pos_next = acc_pos;
                sa_neg_next = acc_neg;
                x_next      = b_reg;
                acc_next    = cube_shifted;
            end
            bcrf_pkg::UOP_CHECK:
            begin
                err_next = stat.same_sign;
                if (!stat.same_sign && sa_pos_reg)
                begin
                    a_next = b_reg;
                    b_next = a_reg;
                end
            end
            bcrf_pkg::UOP_LOOP:
            begin
                x_next   = ab_sum[X_BITS:1];
                acc_next = cube_shifted;
            end
            bcrf_pkg::UOP_UPDATE:
            begin
                if (acc_pos)
                begin
                    b_next = x_reg;
                end
                else
                begin
                    a_next = x_reg;
                end
            end
            bcrf_pkg::UOP_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    root_next      = err_reg ? '0 : a_reg;
                    nsc_next       = err_reg;
                end
            end
            bcrf_pkg::UOP_MUL_HI:
            begin
                prod_next = prod_full;
            end
            bcrf_pkg::UOP_MUL_LO:
            begin
                sum_next  = prod_reg;
                prod_next = prod_full;
            end
            bcrf_pkg::UOP_ADD,
            bcrf_pkg::UOP_ADD_RET:
            begin
                acc_next = horner_sum;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        x_reg      <= x_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        sum_reg    <= sum_next;
        sa_pos_reg <= sa_pos_next;
        sa_neg_reg <= sa_neg_next;
        err_reg    <= err_next;
        root_reg   <= root_next;
        nsc_reg    <= nsc_next;
    end

    assign out_valid      = out_valid_reg;
    assign root           = root_reg;
    assign no_sign_change = nsc_reg;

endmodule

// File: hdl/bisection_cubic_root_finder_core.sv
// Bisection root finder for an integer-coefficient cubic over one signed fixed-point interval
// per input beat. Each evaluation of f runs Horner's rule as three stages of three steps on a
// single shared multiplier. The interval is halved until |a-b| <= tolerance (about log2 of
// interval width over tolerance halvings); an item with no sign change skips the halvings and
// returns a zero root with no_sign_change set. The next item is taken once the result sits in
// the output register.
// depends on bcrf_pkg, bcrf_useq, bcrf_datapath
module bisection_cubic_root_finder_core
#(
    parameter int FRAC_BITS = 16,
    parameter int X_BITS    = 24
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bcrf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bcrf_pkg::TOL_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [X_BITS-1:0]             interval_start,
    input  logic signed [X_BITS-1:0]             interval_end,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [X_BITS-1:0]             root,
    output logic                                 no_sign_change
);

    bcrf_pkg::cfg_t  cfg_reg;
    bcrf_pkg::cfg_t  cfg_next;
    bcrf_pkg::ctl_t  ctl;
    bcrf_pkg::stat_t stat;

    assign cfg_ready = 1'b1;
    assign in_stall  = (ctl.uop != bcrf_pkg::UOP_WAIT);

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                bcrf_pkg::REG_COEF_CUBE:   cfg_next.cube   = cfg_data[bcrf_pkg::COEF_W-1:0];
                bcrf_pkg::REG_COEF_SQUARE: cfg_next.square = cfg_data[bcrf_pkg::COEF_W-1:0];
                bcrf_pkg::REG_COEF_LINEAR: cfg_next.linear = cfg_data[bcrf_pkg::COEF_W-1:0];
                bcrf_pkg::REG_COEF_CONST:  cfg_next.offset = cfg_data[bcrf_pkg::COEF_W-1:0];
                bcrf_pkg::REG_TOLERANCE:   cfg_next.tol    = cfg_data;
                default:                   cfg_next        = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cube   <= bcrf_pkg::RST_COEF_CUBE;
            cfg_reg.square <= bcrf_pkg::RST_COEF_SQUARE;
            cfg_reg.linear <= bcrf_pkg::RST_COEF_LINEAR;
            cfg_reg.offset <= bcrf_pkg::RST_COEF_CONST;
            cfg_reg.tol    <= bcrf_pkg::RST_TOLERANCE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bcrf_useq u_useq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .ctl      (ctl)
    );

    bcrf_datapath
    #(
        .FRAC_BITS (FRAC_BITS),
        .X_BITS    (X_BITS)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .cfg            (cfg_reg),
        .in_valid       (in_valid),
        .interval_start (interval_start),
        .interval_end   (interval_end),
        .out_stall      (out_stall),
        .stat           (stat),
        .out_valid      (out_valid),
        .root           (root),
        .no_sign_change (no_sign_change)
    );

endmodule

// File: hdl/bcrf_checker.sv
// bcrf_checker: port-level assertions for the bisection root finder, bound to the top level
// depends only on the ports of bisection_cubic_root_finder_core
module bcrf_checker
#(
    parameter int X_BITS = 24
)
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic signed [X_BITS-1:0] root,
    input logic                     no_sign_change
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(root) && $stable(no_sign_change))
        else $error("result beat changed while stalled");

    // error results carry a zero root
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_sign_change |-> root == '0)
        else $error("no sign change reported with non-zero root");

    // busy right after taking an interval
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    // a new result only appears while the input side is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result produced without work in progress");

endmodule

bind bisection_cubic_root_finder_core bcrf_checker
#(
    .X_BITS (X_BITS)
)
u_bcrf_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .root           (root),
    .no_sign_change (no_sign_change)
);

// File: test/bcrf_root_checker.sv
// bcrf_root_checker: watches the config, interval and root channels of the bisection root
// finder, predicts each root from its own copy of the registers and compares it field by field
// depends on bcrf_pkg
module bcrf_root_checker
    import bcrf_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int X_BITS    = 24
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [TOL_W-1:0]            cfg_data,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic signed [X_BITS-1:0]    interval_start,
    input  logic signed [X_BITS-1:0]    interval_end,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic signed [X_BITS-1:0]    root,
    input  logic                        no_sign_change,
    output int                          err_count,
    output int                          pending,
    output int                          roots_found,
    output int                          flat_count
);

    localparam longint Q_ONE  = longint'(1) << FRAC_BITS;
    localparam longint HI_CAP = longint'(1) << (62 - X_BITS);

    typedef struct packed {
        logic signed [X_BITS-1:0] root;
        logic                     flat;
    } root_beat_t;

    cfg_t       poly;
    root_beat_t roots_due[$];
    root_beat_t want;

    function automatic longint horner_step(input longint acc, input longint x,
                                           input logic signed [COEF_W-1:0] c);
        longint hi;
        longint lo;
        hi = acc >>> FRAC_BITS;
        lo = acc - hi * Q_ONE;
        if (hi > HI_CAP)
            hi = HI_CAP;
        if (hi < -HI_CAP)
            hi = -HI_CAP;
        return hi * x + ((lo * x) >>> FRAC_BITS) + longint'(c) * Q_ONE;
    endfunction

    function automatic int cubic_sign(input longint x);
        longint acc;
        acc = longint'($signed(poly.cube)) * Q_ONE;
        acc = horner_step(acc, x, poly.square);
        acc = horner_step(acc, x, poly.linear);
        acc = horner_step(acc, x, poly.offset);
        return (acc > 0) ? 1 : ((acc < 0) ? -1 : 0);
    endfunction

    function automatic root_beat_t bisect_cubic(input logic signed [X_BITS-1:0] s,
                                                input logic signed [X_BITS-1:0] e);
        longint     a;
        longint     b;
        longint     t;
        longint     mid;
        longint     tol;
        int         sa;
        int         sb;
        root_beat_t r;
        a      = longint'(s);
        b      = longint'(e);
        tol    = (poly.tol == '0) ? longint'(1) : longint'(poly.tol);
        sa     = cubic_sign(a);
        sb     = cubic_sign(b);
        r.root = '0;
        r.flat = 1'b1;
        if ((sa > 0 && sb > 0) || (sa < 0 && sb < 0))
            return r;
        if (sa > 0)
        begin
            t = a;
            a = b;
            b = t;
        end
        while (((a > b) ? a - b : b - a) > tol)
        begin
            mid = (a + b) >>> 1;
            if (cubic_sign(mid) > 0)
                b = mid;
            else
                a = mid;
        end
        r.root = a[X_BITS-1:0];
        r.flat = 1'b0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly.cube   = RST_COEF_CUBE;
            poly.square = RST_COEF_SQUARE;
            poly.linear = RST_COEF_LINEAR;
            poly.offset = RST_COEF_CONST;
            poly.tol    = RST_TOLERANCE;
            roots_due.delete();
            err_count   = 0;
            pending     = 0;
            roots_found = 0;
            flat_count  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_COEF_CUBE:   poly.cube   = cfg_data[COEF_W-1:0];
                    REG_COEF_SQUARE: poly.square = cfg_data[COEF_W-1:0];
                    REG_COEF_LINEAR: poly.linear = cfg_data[COEF_W-1:0];
                    REG_COEF_CONST:  poly.offset = cfg_data[COEF_W-1:0];
                    REG_TOLERANCE:   poly.tol    = cfg_data;
                    default:         ;
                endcase
            end
            if (in_valid && !in_stall)
                roots_due.push_back(bisect_cubic(interval_start, interval_end));
            if (out_valid && !out_stall)
            begin
                if (roots_due.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected result beat, root %0d no_sign_change %0b",
                             $time, root, no_sign_change);
                end
                else
                begin
                    want = roots_due.pop_front();
                    if (root !== want.root)
                    begin
                        err_count++;
                        $display("%0t: root expected %0d, got %0d", $time, want.root, root);
                    end
                    if (no_sign_change !== want.flat)
                    begin
                        err_count++;
                        $display("%0t: no_sign_change expected %0b, got %0b",
                                 $time, want.flat, no_sign_change);
                    end
                    if (want.flat)
                        flat_count++;
                    else
                        roots_found++;
                end
            end
            pending = roots_due.size();
        end
    end

endmodule

// File: test/bisection_cubic_root_finder_core_tb.sv
// bisection_cubic_root_finder_core_tb: drives intervals and register writes into the root finder
// under random idling and stalls, and gives the verdict from the checker's error count
// depends on bcrf_pkg, bcrf_root_checker and the block under test
module bisection_cubic_root_finder_core_tb;

    import bcrf_pkg::*;

    localparam int XW         = 24;
    localparam int Q_ONE      = 1 << 16;
    localparam int X_MIN      = -8388608;
    localparam int X_MAX      = 8388607;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_SPAN  = 600;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  cfg_valid      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index      = REG_COEF_CUBE;
    logic [TOL_W-1:0]      cfg_data       = '0;
    logic                  in_valid       = 1'b0;
    logic signed [XW-1:0]  interval_start = '0;
    logic signed [XW-1:0]  interval_end   = '0;
    logic                  out_stall      = 1'b0;
    logic                  cfg_ready;
    logic                  in_stall;
    logic                  out_valid;
    logic signed [XW-1:0]  root;
    logic                  no_sign_change;

    int err_count;
    int pending;
    int roots_found;
    int flat_count;
    int idle_cycles  = 0;
    int beats_sent   = 0;
    int settings_run = 0;
    bit steady       = 1'b0;
    bit rx_hold_req  = 1'b0;

    bisection_cubic_root_finder_core i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .interval_start (interval_start),
        .interval_end   (interval_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .root           (root),
        .no_sign_change (no_sign_change)
    );

    bcrf_root_checker i_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .interval_start (interval_start),
        .interval_end   (interval_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .root           (root),
        .no_sign_change (no_sign_change),
        .err_count      (err_count),
        .pending        (pending),
        .roots_found    (roots_found),
        .flat_count     (flat_count)
    );

    initial
    begin
        forever
            #5 clk = ~clk;
    end

    // receiver: random stalls, or one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                out_stall   = 1'b1;
                repeat (HOLD_SPAN) @(negedge clk);
                out_stall   = 1'b0;
            end
            else
                out_stall = !steady && ($urandom_range(99) < 36);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
            $display("bisection_cubic_root_finder_core_tb: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic wait_drained();
        in_valid = 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TOL_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_setting(input int c3, input int c2, input int c1, input int c0,
                                 input int tol);
        wait_drained();
        write_reg(REG_COEF_CUBE, TOL_W'(c3));
        write_reg(REG_COEF_SQUARE, TOL_W'(c2));
        write_reg(REG_COEF_LINEAR, TOL_W'(c1));
        write_reg(REG_COEF_CONST, TOL_W'(c0));
        write_reg(REG_TOLERANCE, TOL_W'(tol));
        settings_run++;
    endtask

    task automatic send_interval(input int s, input int e);
        while (!steady && $urandom_range(99) < 36)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid       = 1'b1;
        interval_start = XW'(s);
        interval_end   = XW'(e);
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        beats_sent++;
    endtask

    function automatic int pick_corner();
        case ($urandom_range(6))
            0:       return X_MIN;
            1:       return X_MAX;
            2:       return 0;
            3:       return -1;
            4:       return 1;
            5:       return Q_ONE;
            default: return -Q_ONE;
        endcase
    endfunction

    task automatic send_random();
        int s;
        int e;
        int t;
        int kind;
        kind = $urandom_range(9);
        if (kind < 6)
        begin
            // wide bracket around the origin, either way round
            s = -int'($urandom_range(8388608, 1));
            e = int'($urandom_range(X_MAX, 0));
            if ($urandom_range(1))
            begin
                t = s;
                s = e;
                e = t;
            end
        end
        else if (kind < 8)
        begin
            s = int'($urandom());
            e = int'($urandom());
        end
        else if (kind == 8)
        begin
            s = int'($urandom());
            e = s + int'($urandom_range(400));
        end
        else
        begin
            s = pick_corner();
            e = pick_corner();
        end
        send_interval(s, e);
    endtask

    task automatic run_random(input int count, input bit squeeze, input bit pause_midway);
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2 && squeeze)
                rx_hold_req = 1'b1;
            if (i == count / 2 && pause_midway)
                wait_drained();
            send_random();
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset polynomial, roots near -3.7, 0.017 and 8.2
        send_interval(0, Q_ONE);
        send_interval(Q_ONE, 0);
        send_interval(-4 * Q_ONE, -3 * Q_ONE);
        send_interval(8 * Q_ONE, 9 * Q_ONE);
        send_interval(X_MIN, X_MAX);
        send_interval(X_MAX, X_MIN);
        send_interval(X_MIN, X_MIN);
        send_interval(X_MAX, X_MAX);
        send_interval(0, 0);
        send_interval(2 * Q_ONE, 3 * Q_ONE);
        run_random(80, 1'b1, 1'b0);

        // x^3 - 4x: exact zeros at the ends, zero tolerance
        apply_setting(1, 0, -4, 0, 0);
        send_interval(0, 3 * Q_ONE);
        send_interval(-2 * Q_ONE, Q_ONE);
        send_interval(2 * Q_ONE, 2 * Q_ONE);
        send_interval(-3 * Q_ONE, -Q_ONE);
        run_random(80, 1'b0, 1'b1);

        apply_setting(32767, -32768, -32768, 32767, 1);
        send_interval(X_MIN, X_MAX);
        send_interval(X_MAX, X_MIN);
        run_random(80, 1'b0, 1'b0);

        apply_setting(-32768, 32767, 32767, -32768, 16777215);
        send_interval(X_MIN, X_MAX);
        send_interval(X_MAX, X_MIN);
        run_random(70, 1'b0, 1'b0);

        apply_setting(0, 0, 0, 0, int'(RST_TOLERANCE));
        send_interval(X_MIN, X_MAX);
        run_random(70, 1'b0, 1'b0);

        apply_setting(0, 0, 5, -3, 300);
        run_random(70, 1'b0, 1'b0);

        steady = 1'b1;
        apply_setting(int'($urandom()), int'($urandom()), int'($urandom()), int'($urandom()),
                      int'($urandom_range(2048, 1)));
        run_random(70, 1'b0, 1'b0);
        steady = 1'b0;

        for (int k = 0; k < 3; k++)
        begin
            apply_setting(int'($urandom()), int'($urandom()), int'($urandom()),
                          int'($urandom()), int'($urandom_range(4095, 1)));
            run_random(70, 1'b0, 1'b0);
        end

        apply_setting(int'(RST_COEF_CUBE), int'(RST_COEF_SQUARE), int'(RST_COEF_LINEAR),
                      int'(RST_COEF_CONST), int'(RST_TOLERANCE));
        run_random(80, 1'b1, 1'b1);

        wait_drained();
        repeat (40) @(negedge clk);

        $display("covered %0d intervals over %0d register settings besides the reset values",
                 beats_sent, settings_run);
        $display("%0d bracketed roots and %0d intervals without a sign change were checked",
                 roots_found, flat_count);
        if (err_count == 0)
            $display("bisection_cubic_root_finder_core_tb: clean");
        else
            $display("bisection_cubic_root_finder_core_tb: errors");
        $finish;
    end

endmodule
